// ----- rtl/tpp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types, layout offsets and character codes for the traceparent
// header parser.
// ----------------------------------------------------------------------------
package tpp_pkg;

    // Character position counter, saturating one past the checked layout
    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] POS_SAT      = 6'd56;
    localparam logic [POS_W-1:0] POS_VER_HI   = 6'd0;
    localparam logic [POS_W-1:0] POS_VER_LO   = 6'd1;
    localparam logic [POS_W-1:0] POS_DASH_0   = 6'd2;
    localparam logic [POS_W-1:0] POS_TID_HI_0 = 6'd3;
    localparam logic [POS_W-1:0] POS_TID_HI_1 = 6'd18;
    localparam logic [POS_W-1:0] POS_TID_LO_1 = 6'd34;
    localparam logic [POS_W-1:0] POS_DASH_1   = 6'd35;
    localparam logic [POS_W-1:0] POS_PID_0    = 6'd36;
    localparam logic [POS_W-1:0] POS_PID_1    = 6'd51;
    localparam logic [POS_W-1:0] POS_DASH_2   = 6'd52;
    localparam logic [POS_W-1:0] POS_FLG_HI   = 6'd53;
    localparam logic [POS_W-1:0] POS_FLG_LO   = 6'd54;
    localparam logic [POS_W-1:0] POS_TAIL     = 6'd55;

    // Shortest acceptable header ends on the flags low digit
    localparam logic [POS_W-1:0] POS_LEN_MIN  = POS_FLG_LO;

    // Character codes
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;

    // Version codes
    localparam logic [7:0] VER_ZERO = 8'h00;
    localparam logic [7:0] VER_BAD  = 8'hFF;

    // Queue depth between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_IDX_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // What the back end does with one character
    typedef enum logic [3:0] {
        OP_NIB,      // keep high digit of version or flags
        OP_VER,      // complete version byte
        OP_FLAGS,    // complete flags byte
        OP_DASH,     // separator check
        OP_TID_HI,   // shift into upper trace id half
        OP_TID_LO,   // shift into lower trace id half
        OP_PID,      // shift into parent id
        OP_TAIL,     // character after the flags
        OP_SKIP      // past the layout, ignored
    } t_op;

    // Classified character handed from front to back
    typedef struct packed {
        t_op        op;
        logic [3:0] digit;    // hex value, zero when not a digit
        logic       bad;      // not a lower-case hex digit
        logic       dash;     // character is '-'
        logic       len_ok;   // header reached minimum length here
        logic       last;     // final character of the header
    } t_item;

    // Decode one character as lower-case hex; bit 4 set means not a digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            return {1'b0, d[3:0]};
        end
        if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = c - CH_LOW_A + 8'd10;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tpp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_if
// Valid/ready channels for header characters and parse results.
// ----------------------------------------------------------------------------
interface tpp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, char_in, is_last, input ready);
    modport sink   (input valid, char_in, is_last, output ready);
endinterface

interface tpp_result_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [63:0] trace_id_high;
    logic [63:0] trace_id_low;
    logic [63:0] parent_id;
    logic [7:0]  flags_byte;

    modport source (output valid, header_ok, trace_id_high, trace_id_low, parent_id,
                    flags_byte, input ready);
    modport sink   (input valid, header_ok, trace_id_high, trace_id_low, parent_id,
                    flags_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/tpp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_front
// Accepts header characters, tracks the position in the layout and
// classifies each character for the back end.
// ----------------------------------------------------------------------------
module tpp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tpp_char_if.sink           i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output tpp_pkg::t_item     o_item
);
    import tpp_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [4:0]       hex;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign hex        = hex_value(i_in.char_in);

    // Classify the character by its position
    always_comb begin
        o_item.digit  = hex[4] ? 4'd0 : hex[3:0];
        o_item.bad    = hex[4];
        o_item.dash   = (i_in.char_in == CH_DASH);
        o_item.len_ok = (r_pos >= POS_LEN_MIN);
        o_item.last   = i_in.is_last;
        priority if (r_pos >= POS_SAT) begin
            o_item.op = OP_SKIP;
        end else if (r_pos == POS_VER_HI || r_pos == POS_FLG_HI) begin
            o_item.op = OP_NIB;
        end else if (r_pos == POS_VER_LO) begin
            o_item.op = OP_VER;
        end else if (r_pos == POS_FLG_LO) begin
            o_item.op = OP_FLAGS;
        end else if (r_pos == POS_DASH_0 || r_pos == POS_DASH_1 || r_pos == POS_DASH_2) begin
            o_item.op = OP_DASH;
        end else if (r_pos >= POS_TID_HI_0 && r_pos <= POS_TID_HI_1) begin
            o_item.op = OP_TID_HI;
        end else if (r_pos > POS_TID_HI_1 && r_pos <= POS_TID_LO_1) begin
            o_item.op = OP_TID_LO;
        end else if (r_pos >= POS_PID_0 && r_pos <= POS_PID_1) begin
            o_item.op = OP_PID;
        end else begin
            o_item.op = OP_TAIL;
        end
    end

    // Advance the position, saturate, restart after the last character
    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in.is_last) begin
                n_pos = '0;
            end else if (r_pos < POS_SAT) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tpp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_queue
// Short register queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module tpp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tpp_pkg::t_item i_item,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output tpp_pkg::t_item     o_item
);
    import tpp_pkg::*;

    t_item              r_slot [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr;
    logic [Q_IDX_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd];

    // Store the beat on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_IDX_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_IDX_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tpp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_back
// Decodes classified characters into version, ids and flags, checks the
// header and holds the result in an output register.
// ----------------------------------------------------------------------------
module tpp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tpp_pkg::t_item i_item,
    output logic               o_pop,
    tpp_result_if.source       o_out
);
    import tpp_pkg::*;

    logic [7:0]  r_version, n_version;
    logic [63:0] r_tid_hi,  n_tid_hi;
    logic [63:0] r_tid_lo,  n_tid_lo;
    logic [63:0] r_pid,     n_pid;
    logic [7:0]  r_flags,   n_flags;
    logic [3:0]  r_nib,     n_nib;
    logic        r_err,     n_err;
    logic        ok;

    logic        r_out_valid;
    logic        r_ok;
    logic [63:0] r_out_tid_hi;
    logic [63:0] r_out_tid_lo;
    logic [63:0] r_out_pid;
    logic [7:0]  r_out_flags;

    // Take a beat when the output register is free or draining
    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    // Apply one character to the decode state
    always_comb begin
        n_version = r_version;
        n_tid_hi  = r_tid_hi;
        n_tid_lo  = r_tid_lo;
        n_pid     = r_pid;
        n_flags   = r_flags;
        n_nib     = r_nib;
        n_err     = r_err;
        unique case (i_item.op)
            OP_NIB: begin
                n_nib = i_item.digit;
                n_err = r_err | i_item.bad;
            end
            OP_VER: begin
                n_version = {r_nib, i_item.digit};
                n_err     = r_err | i_item.bad;
            end
            OP_FLAGS: begin
                n_flags = {r_nib, i_item.digit};
                n_err   = r_err | i_item.bad;
            end
            OP_DASH: begin
                n_err = r_err | !i_item.dash;
            end
            OP_TID_HI: begin
                n_tid_hi = {r_tid_hi[59:0], i_item.digit};
                n_err    = r_err | i_item.bad;
            end
            OP_TID_LO: begin
                n_tid_lo = {r_tid_lo[59:0], i_item.digit};
                n_err    = r_err | i_item.bad;
            end
            OP_PID: begin
                n_pid = {r_pid[59:0], i_item.digit};
                n_err = r_err | i_item.bad;
            end
            OP_TAIL: begin
                // version 00 stops at the flags; later ones need a dash
                n_err = r_err | (r_version == VER_ZERO) | !i_item.dash;
            end
            OP_SKIP: begin
            end
            default: begin
            end
        endcase
        ok = !n_err && i_item.len_ok && (n_version != VER_BAD)
            && ((n_tid_hi | n_tid_lo) != 64'd0) && (n_pid != 64'd0);
    end

    // Hold decode state; clear the error flag between headers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_version <= n_version;
            r_tid_hi  <= n_tid_hi;
            r_tid_lo  <= n_tid_lo;
            r_pid     <= n_pid;
            r_flags   <= n_flags;
            r_nib     <= n_nib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (o_pop) begin
            r_err <= i_item.last ? 1'b0 : n_err;
        end
    end

    // Load the result on the last character; drop fields of a rejected header
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_ok         <= ok;
            r_out_tid_hi <= ok ? n_tid_hi : 64'd0;
            r_out_tid_lo <= ok ? n_tid_lo : 64'd0;
            r_out_pid    <= ok ? n_pid : 64'd0;
            r_out_flags  <= ok ? n_flags : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.header_ok     = r_ok;
    assign o_out.trace_id_high = r_out_tid_hi;
    assign o_out.trace_id_low  = r_out_tid_lo;
    assign o_out.parent_id     = r_out_pid;
    assign o_out.flags_byte    = r_out_flags;

endmodule
`default_nettype wire

// ----- rtl/traceparent_header_parser.sv -----
`default_nettype none
// Timing: the last character is written to the queue, then decoded into the
//   result register, from which the result beat is taken.
// Throughput: one character per cycle. A waiting result stalls decode; the
//   two-entry queue fills up before input ready drops.
// Reset: synchronous, active low; clears position, queue, error flag and
//   output valid. No clearing pass; ready the cycle after reset ends.
// ----------------------------------------------------------------------------
// traceparent_header_parser
// Character-serial traceparent header parser: front classifier, queue and
// back-end decoder with a registered result.
// ----------------------------------------------------------------------------
module traceparent_header_parser (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tpp_char_if.sink      i_in,
    tpp_result_if.source  o_out
);
    import tpp_pkg::*;

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_item front_item;
    t_item q_item;

    tpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_item  (front_item)
    );

    tpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    tpp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    // A stalled result blocks the back end
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !pop)
        else $error("back end advanced while result stalled");

    // Input backpressure only when the queue holds work
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_valid)
        else $error("input stalled with empty queue");

    // Rejected headers carry zero fields
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.header_ok) |-> (o_out.trace_id_high == 64'd0
            && o_out.trace_id_low == 64'd0 && o_out.parent_id == 64'd0
            && o_out.flags_byte == 8'd0))
        else $error("rejected header with nonzero fields");

endmodule
`default_nettype wire

// ----- tb/tb_traceparent_header_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_traceparent_header_parser
// Streams trace-context headers one character per beat into the parser and
// checks every parse result against an in-bench decoder of the header layout.
// Directed headers cover the field extremes, each separator, bad digits, the
// version rules, short, long and one-character headers. Random headers follow
// under four pacing modes for the character and result channels.
// ----------------------------------------------------------------------------
module tb_traceparent_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import tpp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LINE_LEN     = 55;
    localparam int N_PHASES     = 4;
    localparam int IDLE_PCT[N_PHASES]  = '{0, 84, 0, 33};
    localparam int STALL_PCT[N_PHASES] = '{0, 0, 84, 33};

    typedef struct packed {
        logic        ok;
        logic [63:0] tid_hi;
        logic [63:0] tid_lo;
        logic [63:0] pid;
        logic [7:0]  flags;
    } t_hdr_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tpp_char_if   char_if ();
    tpp_result_if result_if ();

    traceparent_header_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (result_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Decoder state for the header in flight
    logic [5:0]  cur_pos;
    logic [7:0]  cur_ver;
    logic [63:0] cur_tid_hi;
    logic [63:0] cur_tid_lo;
    logic [63:0] cur_pid;
    logic [7:0]  cur_flags;
    logic [3:0]  cur_nibble;
    logic        cur_broken;

    t_hdr_result pending_headers[$];
    logic [7:0]  line_buf[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int headers_sent   = 0;
    int results_seen   = 0;
    int results_ok     = 0;
    int chars_sent     = 0;
    int quiet_cycles   = 0;

    task automatic clear_parse_state();
        cur_pos    = '0;
        cur_ver    = '0;
        cur_tid_hi = '0;
        cur_tid_lo = '0;
        cur_pid    = '0;
        cur_flags  = '0;
        cur_nibble = '0;
        cur_broken = 1'b0;
    endtask

    // Advance the decoder by one accepted character; queue a result on last
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [5:0]  p;
        logic [3:0]  d;
        logic        bad;
        t_hdr_result r;
        p   = cur_pos;
        bad = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c[3:0];
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            d = c[3:0] + 4'd9;
        end else begin
            d   = 4'd0;
            bad = 1'b1;
        end

        if (p < POS_SAT) begin
            if (p == POS_VER_HI || p == POS_FLG_HI) begin
                cur_nibble = d;
                cur_broken |= bad;
            end else if (p == POS_VER_LO) begin
                cur_ver = {cur_nibble, d};
                cur_broken |= bad;
            end else if (p == POS_FLG_LO) begin
                cur_flags = {cur_nibble, d};
                cur_broken |= bad;
            end else if (p == POS_DASH_0 || p == POS_DASH_1 || p == POS_DASH_2) begin
                cur_broken |= (c != CH_DASH);
            end else if (p >= POS_TID_HI_0 && p <= POS_TID_HI_1) begin
                cur_tid_hi = {cur_tid_hi[59:0], d};
                cur_broken |= bad;
            end else if (p > POS_TID_HI_1 && p <= POS_TID_LO_1) begin
                cur_tid_lo = {cur_tid_lo[59:0], d};
                cur_broken |= bad;
            end else if (p >= POS_PID_0 && p <= POS_PID_1) begin
                cur_pid = {cur_pid[59:0], d};
                cur_broken |= bad;
            end else begin
                // Character after the flags: only a later version may go on
                if (cur_ver == VER_ZERO || c != CH_DASH) cur_broken = 1'b1;
            end
            cur_pos = p + 6'd1;
        end

        if (last) begin
            r = '0;
            if (!cur_broken && p >= POS_LEN_MIN && cur_ver != VER_BAD
                    && (cur_tid_hi | cur_tid_lo) != '0 && cur_pid != '0) begin
                r.ok     = 1'b1;
                r.tid_hi = cur_tid_hi;
                r.tid_lo = cur_tid_lo;
                r.pid    = cur_pid;
                r.flags  = cur_flags;
            end
            pending_headers = {pending_headers, r};
            clear_parse_state();
        end
    endtask

    // Drive one character beat; valid stays high afterwards unless idled
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            char_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_if.valid   <= 1'b1;
        char_if.char_in <= c;
        char_if.is_last <= last;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        parse_char(c, last);
    endtask

    // Send the line buffer as one header; count the beats the block looks at
    task automatic send_line(output int n_seen);
        n_seen = 0;
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
            if (i < POS_SAT) n_seen++;
        end
        chars_sent += n_seen;
        headers_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_LOW_A + 8'(n - 4'd10);
    endfunction

    // Append one character to the line buffer
    task automatic put_char(input logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic put_hex(input logic [63:0] v, input int ndig);
        for (int k = ndig - 1; k >= 0; k--) put_char(hex_char(v[4*k +: 4]));
    endtask

    task automatic build_header(input logic [7:0] ver, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [63:0] pid,
                                input logic [7:0] flags);
        line_buf.delete();
        put_hex(64'(ver), 2);
        put_char(CH_DASH);
        put_hex(hi, 16);
        put_hex(lo, 16);
        put_char(CH_DASH);
        put_hex(pid, 16);
        put_char(CH_DASH);
        put_hex(64'(flags), 2);
    endtask

    // Byte that is fully random, just outside a legal hex range, upper case, a dash or a space
    function automatic logic [7:0] odd_char();
        if ($urandom_range(1) == 0) return 8'($urandom_range(255));
        case ($urandom_range(7))
            0:       return 8'h2F;
            1:       return 8'h3A;
            2:       return 8'h60;
            3:       return 8'h67;
            4:       return 8'h41;
            5:       return 8'h46;
            6:       return CH_DASH;
            default: return 8'h20;
        endcase
    endfunction

    task automatic add_tail(input logic [7:0] first, input int n);
        put_char(first);
        repeat (n) put_char(8'($urandom_range(255)));
    endtask

    // Hold the sender until every queued result has been taken
    task automatic wait_headers_done();
        char_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_headers.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_wellformed_headers();
        int n;
        // typical version 00 header
        build_header(VER_ZERO, 64'h4bf92f3577b34da6, 64'ha3ce929d0e0e4736,
                     64'h00f067aa0ba902b7, 8'h01);
        send_line(n);
        // every id and flag digit at its top value
        build_header(VER_ZERO, '1, '1, '1, 8'hFF);
        send_line(n);
        // smallest nonzero ids, flags clear
        build_header(VER_ZERO, '0, 64'h1, 64'h1, 8'h00);
        send_line(n);
        build_header(VER_ZERO, 64'h1, '0, 64'h8000000000000000, 8'h80);
        send_line(n);
        // later version ending at the fixed length
        build_header(8'h01, 64'h0123456789abcdef, 64'hfedcba9876543210,
                     64'h0f1e2d3c4b5a6978, 8'h5a);
        send_line(n);
        // later version, separator after the flags and nothing more
        build_header(8'h01, 64'h1111, 64'h2222, 64'h3333, 8'h03);
        put_char(CH_DASH);
        send_line(n);
        // highest legal version, long tail past the saturation point
        build_header(8'hFE, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 8'hA5);
        add_tail(CH_DASH, 14);
        put_char(8'h00);
        put_char(8'hFF);
        send_line(n);
    endtask

    task automatic test_broken_headers();
        int n;
        logic [5:0] seps[3];
        seps = '{POS_DASH_0, POS_DASH_1, POS_DASH_2};
        // reserved version
        build_header(VER_BAD, 64'h1, 64'h2, 64'h3, 8'h01);
        send_line(n);
        // version 00 with one character too many
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        put_char(CH_DASH);
        send_line(n);
        // later version, wrong character after the flags
        build_header(8'h02, 64'h1, 64'h2, 64'h3, 8'h01);
        add_tail(8'h2E, 3);
        send_line(n);
        // each separator replaced
        for (int k = 0; k < 3; k++) begin
            build_header(VER_ZERO, 64'hab, 64'hcd, 64'hef, 8'h01);
            line_buf[seps[k]] = 8'h5F;
            send_line(n);
        end
        // upper-case digit inside the trace id
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        line_buf[POS_TID_HI_0 + 6'd4] = 8'h41;
        send_line(n);
        // bad version digit
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        line_buf[POS_VER_HI] = 8'h67;
        send_line(n);
        // bad flags digit and bad parent digit
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        line_buf[POS_FLG_LO] = 8'h3A;
        send_line(n);
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        line_buf[POS_PID_1] = 8'h2F;
        send_line(n);
        // all-zero trace id, then all-zero parent id
        build_header(VER_ZERO, '0, '0, 64'h3, 8'h01);
        send_line(n);
        build_header(VER_ZERO, 64'h1, 64'h2, '0, 8'h01);
        send_line(n);
        // header one character short
        build_header(VER_ZERO, 64'h1, 64'h2, 64'h3, 8'h01);
        void'(line_buf.pop_back());
        send_line(n);
        // one-character headers
        line_buf.delete();
        put_char(8'h00);
        send_line(n);
        line_buf.delete();
        put_char(8'hFF);
        send_line(n);
    endtask

    // Mostly well-formed headers with random content, the rest damaged or noise
    task automatic test_random_headers(input int min_chars, input int min_headers);
        int          kind;
        int          cut;
        int          n;
        int          chars;
        int          hdrs;
        logic [7:0]  ver;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] pid;
        chars = 0;
        hdrs  = 0;
        while (chars < min_chars || hdrs < min_headers) begin
            kind = $urandom_range(99);
            case ($urandom_range(3))
                0, 1:    ver = VER_ZERO;
                2:       ver = 8'($urandom_range(254, 1));
                default: ver = ($urandom_range(9) == 0) ? VER_BAD : 8'($urandom_range(255));
            endcase
            hi  = {$urandom, $urandom};
            lo  = {$urandom, $urandom};
            pid = {$urandom, $urandom};
            if ($urandom_range(15) == 0) begin
                hi = '0;
                lo = 64'($urandom_range(1));
            end
            if ($urandom_range(15) == 0) pid = 64'($urandom_range(1));
            build_header(ver, hi, lo, pid, 8'($urandom_range(255)));

            if (kind < 55) begin
                if (ver != VER_ZERO && $urandom_range(1) == 1)
                    add_tail(CH_DASH, $urandom_range(12));
            end else if (kind < 72) begin
                line_buf[$urandom_range(LINE_LEN - 1)] = odd_char();
            end else if (kind < 85) begin
                cut = $urandom_range(LINE_LEN - 1, 1);
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end else if (kind < 93) begin
                add_tail(odd_char(), $urandom_range(15));
            end else begin
                line_buf.delete();
                repeat ($urandom_range(60, 1)) put_char(8'($urandom_range(255)));
            end

            send_line(n);
            chars += n;
            hdrs++;
        end
    endtask

    // Take result beats and compare each with the oldest queued header
    always @(posedge i_clk) begin : result_check
        t_hdr_result want;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                results_seen++;
                if (pending_headers.size() == 0) begin
                    $error("result beat with no header pending");
                    mismatches++;
                end else begin
                    want = pending_headers.pop_front();
                    if (want.ok) results_ok++;
                    if (result_if.header_ok !== want.ok) begin
                        $error("header_ok: expected %0d, got %0d", want.ok,
                               result_if.header_ok);
                        mismatches++;
                    end
                    if (result_if.trace_id_high !== want.tid_hi) begin
                        $error("trace_id_high: expected %h, got %h", want.tid_hi,
                               result_if.trace_id_high);
                        mismatches++;
                    end
                    if (result_if.trace_id_low !== want.tid_lo) begin
                        $error("trace_id_low: expected %h, got %h", want.tid_lo,
                               result_if.trace_id_low);
                        mismatches++;
                    end
                    if (result_if.parent_id !== want.pid) begin
                        $error("parent_id: expected %h, got %h", want.pid,
                               result_if.parent_id);
                        mismatches++;
                    end
                    if (result_if.flags_byte !== want.flags) begin
                        $error("flags_byte: expected %h, got %h", want.flags,
                               result_if.flags_byte);
                        mismatches++;
                    end
                end
            end
            result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: stop when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (char_if.valid && char_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        char_if.valid     = 1'b0;
        char_if.char_in   = '0;
        char_if.is_last   = 1'b0;
        result_if.ready   = 1'b0;
        clear_parse_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_wellformed_headers();
        test_broken_headers();
        wait_headers_done();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            src_idle_pct   = IDLE_PCT[ph];
            sink_stall_pct = STALL_PCT[ph];
            test_random_headers(40, 1);
            wait_headers_done();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d headers over %0d checked characters in %0d pacing modes;",
                 headers_sent, chars_sent, N_PHASES);
        $display("%0d results compared, %0d of them valid headers, %0d mismatches.",
                 results_seen, results_ok, mismatches);
        if (mismatches == 0 && pending_headers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
